/* rtl/core/ipv4v_pkg.sv */
// types and constants shared by the ipv4 dotted-quad validator
package ipv4v_pkg;

  localparam logic [7:0] CODE_ZERO = 8'd48;
  localparam logic [7:0] CODE_NINE = 8'd57;
  localparam logic [7:0] CODE_DOT  = 8'd46;

  localparam logic [4:0] MIN_CHARS = 5'd7;
  localparam logic [4:0] MAX_CHARS = 5'd15;
  localparam logic [4:0] CHAR_SAT  = 5'd16;
  localparam logic [2:0] NEED_DOTS = 3'd3;
  localparam logic [2:0] DOT_SAT   = 3'd4;
  localparam logic [8:0] OCTET_MAX = 9'd255;
  localparam logic [8:0] OCTET_SAT = 9'd256;
  localparam logic [1:0] DIGIT_SAT = 2'd2;

  typedef logic [7:0] char_t;

  // running checks for the token being received
  typedef struct packed {
    logic [4:0] char_count;
    logic [2:0] dot_count;
    logic       prev_was_dot;
    logic [8:0] octet_value;
    logic [1:0] octet_digits;
    logic       error_seen;
  } ipv4v_state_t;

endpackage

/* rtl/core/ipv4v_ifs.sv */
// valid/ready channel interfaces for characters in and verdicts out
interface ipv4v_char_if import ipv4v_pkg::*;;
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface ipv4v_verdict_if import ipv4v_pkg::*;;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

/* rtl/core/ipv4_dotted_quad_validator_top.sv */
// ipv4 dotted-quad validator: one character per cycle unless stalled, one verdict per token
//
// Characters of a token arrive one per transfer on in_chan, the final one flagged by
// is_last. Each accepted character is held in an input register and checked in the
// next cycle against the running counts (characters, dots, current octet value and
// digits, latched fault); on the last character a verdict is written to the output
// register and the counts clear for the next token. A new character is accepted every
// cycle unless the block stalls; the verdict moves from the input register into the
// output register once it is free. The block stalls only while a verdict waits in the
// output register and a further last character is ready to produce another one.
module ipv4_dotted_quad_validator_top import ipv4v_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  ipv4v_char_if.sink     in_chan,
  ipv4v_verdict_if.source out_chan
);

  logic         s1_valid_r;
  char_t        s1_char_r;
  logic         s1_last_r;
  ipv4v_state_t st_r, st_nxt;
  logic         out_valid_r;
  logic         out_res_r;

  logic         out_free;
  logic         s1_adv;
  logic         is_dot, is_digit;
  logic [3:0]   digit;
  logic [11:0]  octet_prod;
  ipv4v_state_t upd;
  logic         verdict;

  function automatic logic octet_bad(input logic [8:0] value, input logic [1:0] digits);
    return (value > OCTET_MAX) || (value == 9'd0 && digits > 2'd1);
  endfunction

  assign out_free     = !out_valid_r || out_chan.ready;
  assign s1_adv       = s1_valid_r && (!s1_last_r || out_free);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  assign is_dot     = (s1_char_r == CODE_DOT);
  assign is_digit   = (s1_char_r >= CODE_ZERO) && (s1_char_r <= CODE_NINE);
  assign digit      = s1_char_r[3:0] - CODE_ZERO[3:0];
  assign octet_prod = {st_r.octet_value, 3'b000} + {2'b00, st_r.octet_value, 1'b0}
                      + {8'd0, digit};

  always_comb begin
    upd = st_r;
    if (st_r.char_count < CHAR_SAT) begin
      upd.char_count = st_r.char_count + 5'd1;
    end
    if (is_dot) begin
      if (st_r.char_count == 5'd0 || st_r.prev_was_dot || s1_last_r ||
          octet_bad(st_r.octet_value, st_r.octet_digits)) begin
        upd.error_seen = 1'b1;
      end
      if (st_r.dot_count < DOT_SAT) begin
        upd.dot_count = st_r.dot_count + 3'd1;
      end
      upd.octet_value  = 9'd0;
      upd.octet_digits = 2'd0;
      upd.prev_was_dot = 1'b1;
    end else if (is_digit) begin
      upd.octet_value  = (octet_prod > {3'b000, OCTET_SAT}) ? OCTET_SAT : octet_prod[8:0];
      if (st_r.octet_digits < DIGIT_SAT) begin
        upd.octet_digits = st_r.octet_digits + 2'd1;
      end
      upd.prev_was_dot = 1'b0;
    end else begin
      upd.error_seen   = 1'b1;
      upd.prev_was_dot = 1'b0;
    end

    // closing checks on the final character; a trailing dot already latched a fault
    verdict = !upd.error_seen
              && !(!is_dot && octet_bad(upd.octet_value, upd.octet_digits))
              && (upd.char_count >= MIN_CHARS) && (upd.char_count <= MAX_CHARS)
              && (upd.dot_count == NEED_DOTS);

    st_nxt = st_r;
    if (s1_adv) begin
      st_nxt = s1_last_r ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_char_r <= in_chan.char_code;
      s1_last_r <= in_chan.is_last;
    end
    if (s1_adv && s1_last_r) begin
      out_res_r <= verdict;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.valid_res = out_res_r;

endmodule

/* rtl/core/ipv4v_checker.sv */
// port-level checks for the ipv4 dotted-quad validator, bound to the top level
module ipv4v_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_is_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_valid_res
);

  // tokens whose last character went in and whose verdict has not gone out
  logic [1:0] pending_r;
  logic       last_in, res_out;

  assign last_in = in_valid && in_ready && in_is_last;
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else if (last_in && !res_out) begin
      pending_r <= pending_r + 2'd1;
    end else if (res_out && !last_in) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped before transfer");

  a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_valid_res))
    else $error("verdict changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("verdict with no finished token");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3 && !(pending_r == 2'd2 && last_in && !res_out))
    else $error("more finished tokens held than the pipeline can store");

endmodule

bind ipv4_dotted_quad_validator_top ipv4v_checker u_ipv4v_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_is_last    (in_chan.is_last),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_valid_res (out_chan.valid_res)
);
